/* src/knn_classifier_top_assert.svh */
// Assertion macros for the classifier's port-level checker
`ifndef KNN_CLASSIFIER_TOP_ASSERT_SVH
`define KNN_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define KNN_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("knn checker: same-cycle rule broken");

// Next-cycle implication, sampled on clk, off while rst is high
`define KNN_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("knn checker: next-cycle rule broken");

`endif

/* src/knn_pkg.sv */
// Shared constants and control types for the k-NN classifier
package knn_pkg;

  // Fixed port widths
  localparam int FEAT_PORT_BITS  = 16;
  localparam int DIST_PORT_BITS  = 34;
  localparam int LABEL_BITS      = 3;
  localparam int CLASS_COUNT     = 8;
  localparam int SLOT_PORT_BITS  = 8;
  localparam int COUNT_PORT_BITS = 9;
  localparam int NBR_PORT_BITS   = 3;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 9;

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEIGHBOR_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRAIN_COUNT    = 2'd1;

  // Commands from the sequencer to the neighbour list
  typedef struct packed {
    logic clear;
    logic insert;
    logic vote;
  } rank_ctrl_t;

  // Vote outcome from the neighbour list
  typedef struct packed {
    logic                      done;
    logic [LABEL_BITS-1:0]     label;
    logic [NBR_PORT_BITS-1:0]  votes;
  } rank_res_t;

endpackage

/* src/knn_dist_unit.sv */
// Pipelined squared-distance unit: one sample per cycle, three stages
module knn_dist_unit #(
  parameter int FW = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [4*FW-1:0]                   query,
  input  logic [4*FW-1:0]                   sample,
  input  logic [knn_pkg::LABEL_BITS-1:0]    sample_label,
  output logic                              out_valid,
  output logic [2*FW+1:0]                   dist_sum,
  output logic [knn_pkg::LABEL_BITS-1:0]    out_label,
  output logic                              busy
);

  localparam int DW = 2*FW+2;
  localparam int SW = 2*FW;

  logic [FW-1:0]                   diff_c [4];
  logic [FW-1:0]                   diff_q [4];
  logic [SW-1:0]                   sq_q   [4];
  logic                            v1;
  logic                            v2;
  logic                            v3;
  logic [knn_pkg::LABEL_BITS-1:0]  lab1;
  logic [knn_pkg::LABEL_BITS-1:0]  lab2;
  logic [knn_pkg::LABEL_BITS-1:0]  lab3;

  // Absolute difference per feature
  always_comb begin
    for (int f = 0; f < 4; f++) begin
      if (query[f*FW +: FW] > sample[f*FW +: FW]) begin
        diff_c[f] = query[f*FW +: FW] - sample[f*FW +: FW];
      end else begin
        diff_c[f] = sample[f*FW +: FW] - query[f*FW +: FW];
      end
    end
  end

  // Advance the valid tokens
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Difference, square, sum
  always_ff @(posedge clk) begin
    for (int f = 0; f < 4; f++) begin
      diff_q[f] <= diff_c[f];
      sq_q[f]   <= SW'(diff_q[f]) * SW'(diff_q[f]);
    end
    dist_sum <= DW'(sq_q[0]) + DW'(sq_q[1]) + DW'(sq_q[2]) + DW'(sq_q[3]);
    lab1 <= sample_label;
    lab2 <= lab1;
    lab3 <= lab2;
  end

  assign out_valid = v3;
  assign out_label = lab3;
  assign busy      = v1 | v2 | v3;

endmodule

/* src/knn_rank.sv */
// Sorted list of the k nearest samples and the plurality vote over it
module knn_rank #(
  parameter int K_MAX = 5,
  parameter int DW    = 34
) (
  input  logic                              clk,
  input  logic                              rst,
  input  knn_pkg::rank_ctrl_t               ctrl,
  input  logic [$clog2(K_MAX+1)-1:0]        k,
  input  logic [DW-1:0]                     ins_dist,
  input  logic [knn_pkg::LABEL_BITS-1:0]    ins_label,
  output knn_pkg::rank_res_t                res,
  output logic [DW-1:0]                     nearest
);

  localparam int KB = $clog2(K_MAX+1);
  localparam int IB = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int LB = knn_pkg::LABEL_BITS;
  localparam int VB = knn_pkg::NBR_PORT_BITS;
  localparam int CC = knn_pkg::CLASS_COUNT;

  localparam logic [1:0] V_IDLE  = 2'd0;
  localparam logic [1:0] V_COUNT = 2'd1;
  localparam logic [1:0] V_PICK  = 2'd2;
  localparam logic [1:0] V_DONE  = 2'd3;

  logic [DW-1:0]  dist_l [K_MAX];
  logic [LB-1:0]  lab_l  [K_MAX];
  logic [KB-1:0]  filled;
  logic [KB-1:0]  votes  [CC];
  logic [KB-1:0]  top_v;
  logic [KB-1:0]  cnt_inc;
  logic [IB-1:0]  p;
  logic [1:0]     vstate;
  logic [LB-1:0]  winner;
  logic           done;
  logic [K_MAX-1:0] le;
  logic [KB-1:0]  k_m1;
  logic           ins_ok;

  // Entries that stay ahead of the new distance (equal ones included)
  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      le[i] = (KB'(i) < filled) && (dist_l[i] <= ins_dist);
    end
  end

  assign k_m1    = k - 1'b1;
  assign ins_ok  = !le[k_m1[IB-1:0]];
  assign cnt_inc = votes[lab_l[p]] + 1'b1;

  // Shift the tail down one place and drop the new sample into the gap
  always_ff @(posedge clk) begin
    if (ctrl.insert && ins_ok) begin
      if (!le[0]) begin
        dist_l[0] <= ins_dist;
        lab_l[0]  <= ins_label;
      end
      for (int i = 1; i < K_MAX; i++) begin
        if (!le[i]) begin
          if (le[i-1]) begin
            dist_l[i] <= ins_dist;
            lab_l[i]  <= ins_label;
          end else begin
            dist_l[i] <= dist_l[i-1];
            lab_l[i]  <= lab_l[i-1];
          end
        end
      end
    end
  end

  // Fill count and the two vote passes
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      filled <= '0;
      vstate <= V_IDLE;
      done   <= 1'b0;
      top_v  <= '0;
      p      <= '0;
      for (int c = 0; c < CC; c++) begin
        votes[c] <= '0;
      end
    end else begin
      if (ctrl.insert && ins_ok && (filled < k)) begin
        filled <= filled + 1'b1;
      end
      case (vstate)
        V_IDLE: begin
          if (ctrl.vote) begin
            p      <= '0;
            vstate <= V_COUNT;
          end
        end
        V_COUNT: begin
          votes[lab_l[p]] <= cnt_inc;
          if (cnt_inc > top_v) begin
            top_v <= cnt_inc;
          end
          if (KB'(p) == filled - 1'b1) begin
            p      <= '0;
            vstate <= V_PICK;
          end else begin
            p <= p + 1'b1;
          end
        end
        V_PICK: begin
          // first entry whose class reached the top count wins
          if (votes[lab_l[p]] == top_v) begin
            winner <= lab_l[p];
            done   <= 1'b1;
            vstate <= V_DONE;
          end else begin
            p <= p + 1'b1;
          end
        end
        V_DONE: begin
          vstate <= V_DONE;
        end
        default: begin
          vstate <= V_IDLE;
        end
      endcase
    end
  end

  assign res.done  = done;
  assign res.label = winner;
  assign res.votes = VB'(top_v);
  assign nearest   = dist_l[0];

endmodule

/* src/knn_classifier_top.sv */
// k-nearest-neighbour classifier: sample store, sequencer and result register
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data   | in
//   in      | in_valid in_ready req_type entry_index   | in
//           | feat_a..feat_d sample_label              |
//   out     | out_valid out_ready class_label          | out
//           | nearest_distance winning_votes no_samples|
//
// A load item writes one row of the sample store.
// During a query the store's single read port feeds one sample per cycle
// into the distance pipeline, then the vote walks the k-entry list twice.
// in_ready is low for the whole query.
// The result sits in an output register; a stalled out channel holds the
// sequencer only when the next query finishes. Synchronous reset, no sweep.
module knn_classifier_top #(
  parameter int TRAIN_DEPTH  = 256,
  parameter int K_MAX        = 5,
  parameter int FEATURE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [knn_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [knn_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   req_type,
  input  logic [knn_pkg::SLOT_PORT_BITS-1:0]     entry_index,
  input  logic [knn_pkg::FEAT_PORT_BITS-1:0]     feat_a,
  input  logic [knn_pkg::FEAT_PORT_BITS-1:0]     feat_b,
  input  logic [knn_pkg::FEAT_PORT_BITS-1:0]     feat_c,
  input  logic [knn_pkg::FEAT_PORT_BITS-1:0]     feat_d,
  input  logic [knn_pkg::LABEL_BITS-1:0]         sample_label,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [knn_pkg::LABEL_BITS-1:0]         class_label,
  output logic [knn_pkg::DIST_PORT_BITS-1:0]     nearest_distance,
  output logic [knn_pkg::NBR_PORT_BITS-1:0]      winning_votes,
  output logic                                   no_samples
);

  localparam int FPB       = knn_pkg::FEAT_PORT_BITS;
  localparam int DPB       = knn_pkg::DIST_PORT_BITS;
  localparam int LB        = knn_pkg::LABEL_BITS;
  localparam int NPB       = knn_pkg::NBR_PORT_BITS;
  localparam int CPB       = knn_pkg::COUNT_PORT_BITS;
  localparam int SPB       = knn_pkg::SLOT_PORT_BITS;
  localparam int FW        = (FEATURE_BITS < FPB) ? FEATURE_BITS : FPB;
  localparam int DW        = 2*FW+2;
  localparam int MEM_W     = 4*FW + LB;
  localparam int ADDR_BITS = $clog2(TRAIN_DEPTH);
  localparam int CNT_BITS  = $clog2(TRAIN_DEPTH+1);
  localparam int CMP_BITS  = (CNT_BITS > CPB) ? CNT_BITS : CPB;
  localparam int SCMP_BITS = (CNT_BITS > SPB) ? CNT_BITS : SPB;
  localparam int KB        = $clog2(K_MAX+1);
  localparam int KCMP_BITS = (KB > NPB) ? KB : NPB;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_VOTE  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]            state;
  logic [NPB-1:0]        nbr_cfg;
  logic [CPB-1:0]        train_cfg;
  logic [KB-1:0]         k_q;
  logic [CNT_BITS-1:0]   count_q;
  logic [ADDR_BITS-1:0]  addr;
  logic [4*FW-1:0]       query_q;
  logic                  empty_q;
  logic                  rd_valid;
  logic [MEM_W-1:0]      rd_data;
  logic [MEM_W-1:0]      mem [TRAIN_DEPTH];

  logic                  in_acc;
  logic                  query_acc;
  logic                  emit_go;
  logic [4*FW-1:0]       in_feats;
  logic [SCMP_BITS-1:0]  slot_ext;
  logic                  slot_ok;
  logic [KCMP_BITS-1:0]  nbr_ext;
  logic [KB-1:0]         k_eff;
  logic [CMP_BITS-1:0]   cnt_ext;
  logic [CNT_BITS-1:0]   count_eff;

  logic                  dist_valid;
  logic [DW-1:0]         dist_sum;
  logic [LB-1:0]         dist_label;
  logic                  dist_busy;
  knn_pkg::rank_ctrl_t   rank_ctrl;
  knn_pkg::rank_res_t    rank_res;
  logic [DW-1:0]         nearest;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign query_acc = in_acc && (req_type == knn_pkg::REQ_QUERY);
  assign emit_go   = (state == ST_EMIT) && (!out_valid || out_ready);
  assign in_feats  = {feat_d[FW-1:0], feat_c[FW-1:0], feat_b[FW-1:0], feat_a[FW-1:0]};
  assign slot_ext  = SCMP_BITS'(entry_index);
  assign slot_ok   = slot_ext < SCMP_BITS'(TRAIN_DEPTH);

  // Clamp k into 1..K_MAX and the sample count to the store depth
  always_comb begin
    nbr_ext = KCMP_BITS'(nbr_cfg);
    if (nbr_ext == '0) begin
      k_eff = KB'(1);
    end else if (nbr_ext > KCMP_BITS'(K_MAX)) begin
      k_eff = KB'(K_MAX);
    end else begin
      k_eff = KB'(nbr_ext);
    end
    cnt_ext = CMP_BITS'(train_cfg);
    if (cnt_ext > CMP_BITS'(TRAIN_DEPTH)) begin
      count_eff = CNT_BITS'(TRAIN_DEPTH);
    end else begin
      count_eff = CNT_BITS'(cnt_ext);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      nbr_cfg   <= NPB'(1);
      train_cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        knn_pkg::CFG_NEIGHBOR_COUNT: nbr_cfg   <= cfg_data[NPB-1:0];
        knn_pkg::CFG_TRAIN_COUNT:    train_cfg <= cfg_data[CPB-1:0];
        default: ;
      endcase
    end
  end

  // Sample store: written by load items, read one row a cycle while scanning
  always_ff @(posedge clk) begin
    if (in_acc && (req_type == knn_pkg::REQ_LOAD) && slot_ok) begin
      mem[slot_ext[ADDR_BITS-1:0]] <= {sample_label, in_feats};
    end
    rd_data <= mem[addr];
  end

  // Query sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_SCAN);
      if (out_valid && out_ready && !emit_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (query_acc) begin
            addr    <= '0;
            empty_q <= (count_eff == '0);
            state   <= (count_eff == '0) ? ST_EMIT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (CNT_BITS'(addr) == count_q - 1'b1) begin
            state <= ST_DRAIN;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!rd_valid && !dist_busy) begin
            state <= ST_VOTE;
          end
        end
        ST_VOTE: begin
          if (rank_res.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // hold until the output register is free
          if (emit_go) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Query operands and result payload
  always_ff @(posedge clk) begin
    if (query_acc) begin
      query_q <= in_feats;
      k_q     <= k_eff;
      count_q <= count_eff;
    end
    if (emit_go) begin
      no_samples <= empty_q;
      if (empty_q) begin
        class_label      <= '0;
        nearest_distance <= '0;
        winning_votes    <= '0;
      end else begin
        class_label      <= rank_res.label;
        nearest_distance <= DPB'(nearest);
        winning_votes    <= rank_res.votes;
      end
    end
  end

  knn_dist_unit #(
    .FW (FW)
  ) u_dist (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (rd_valid),
    .query        (query_q),
    .sample       (rd_data[4*FW-1:0]),
    .sample_label (rd_data[MEM_W-1 -: LB]),
    .out_valid    (dist_valid),
    .dist_sum     (dist_sum),
    .out_label    (dist_label),
    .busy         (dist_busy)
  );

  assign rank_ctrl.clear  = query_acc;
  assign rank_ctrl.insert = dist_valid;
  assign rank_ctrl.vote   = (state == ST_DRAIN) && !rd_valid && !dist_busy;

  knn_rank #(
    .K_MAX (K_MAX),
    .DW    (DW)
  ) u_rank (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (rank_ctrl),
    .k         (k_q),
    .ins_dist  (dist_sum),
    .ins_label (dist_label),
    .res       (rank_res),
    .nearest   (nearest)
  );

endmodule

/* src/knn_chk.sv */
// Port-level checker for the classifier, bound to the top level
`include "knn_classifier_top_assert.svh"

module knn_chk (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                req_type,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [knn_pkg::LABEL_BITS-1:0]      class_label,
  input  logic [knn_pkg::DIST_PORT_BITS-1:0]  nearest_distance,
  input  logic [knn_pkg::NBR_PORT_BITS-1:0]   winning_votes,
  input  logic                                no_samples
);

  // A stalled result keeps its payload
  `KNN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(class_label) && $stable(nearest_distance) && $stable(winning_votes) && $stable(no_samples))

  // An empty query reports all-zero fields
  `KNN_ASSERT_NOW(a_empty_zero, out_valid && no_samples, class_label == '0 && nearest_distance == '0 && winning_votes == '0)

  // A query item closes the input channel while it runs
  `KNN_ASSERT_NEXT(a_query_busy, in_valid && in_ready && req_type == knn_pkg::REQ_QUERY, !in_ready)

  // A load item never raises a result
  `KNN_ASSERT_NEXT(a_load_silent, in_valid && in_ready && req_type == knn_pkg::REQ_LOAD && !out_valid, !out_valid)

  // A result only appears at the end of a query, with the input held off
  `KNN_ASSERT_NOW(a_result_source, $rose(out_valid), $past(!in_ready))

endmodule

bind knn_classifier_top knn_chk u_knn_chk (.*);

/* tb/tb.sv */
// Self-checking testbench for the k-NN classifier: directed corners, random traffic, stalls
module tb;

  localparam int STORE_DEPTH   = 256;
  localparam int VOTE_MAX      = 5;
  localparam int FEAT_WIDTH    = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 300;
  localparam int HOLD_CYCLES   = 800;
  localparam int IDXB          = knn_pkg::CFG_IDX_BITS;
  localparam int DATB          = knn_pkg::CFG_DATA_BITS;
  localparam int SLTB          = knn_pkg::SLOT_PORT_BITS;
  localparam int LBLB          = knn_pkg::LABEL_BITS;
  localparam int DSTB          = knn_pkg::DIST_PORT_BITS;
  localparam int NBRB          = knn_pkg::NBR_PORT_BITS;
  localparam int CNTB          = knn_pkg::COUNT_PORT_BITS;
  localparam int CLASSES       = knn_pkg::CLASS_COUNT;

  // Indexes that name no register; writes to them must change nothing
  localparam logic [IDXB-1:0]       CFG_SPARE_LO = 2'd2;
  localparam logic [IDXB-1:0]       CFG_SPARE_HI = 2'd3;
  localparam logic [FEAT_WIDTH-1:0] FEAT_MAX     = 16'hFFFF;

  typedef enum int {SPREAD_WIDE, SPREAD_CLUSTER, SPREAD_COARSE} spread_t;

  typedef struct packed {
    logic                      req;
    logic [SLTB-1:0]           slot;
    logic [FEAT_WIDTH-1:0]     fa;
    logic [FEAT_WIDTH-1:0]     fb;
    logic [FEAT_WIDTH-1:0]     fc;
    logic [FEAT_WIDTH-1:0]     fd;
    logic [LBLB-1:0]           lbl;
  } knn_item_t;

  typedef struct packed {
    logic [LBLB-1:0]           label;
    logic [DSTB-1:0]           nearest;
    logic [NBRB-1:0]           votes;
    logic                      empty;
  } knn_verdict_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDXB-1:0] cfg_index = '0;
  logic [DATB-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = knn_pkg::REQ_LOAD;
  logic [SLTB-1:0] entry_index = '0;
  logic [knn_pkg::FEAT_PORT_BITS-1:0] feat_a = '0;
  logic [knn_pkg::FEAT_PORT_BITS-1:0] feat_b = '0;
  logic [knn_pkg::FEAT_PORT_BITS-1:0] feat_c = '0;
  logic [knn_pkg::FEAT_PORT_BITS-1:0] feat_d = '0;
  logic [LBLB-1:0] sample_label = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [LBLB-1:0] class_label;
  logic [DSTB-1:0] nearest_distance;
  logic [NBRB-1:0] winning_votes;
  logic no_samples;

  // Shadow of the block: sample store and registers
  logic [4*FEAT_WIDTH-1:0] sample_feat [STORE_DEPTH];
  logic [LBLB-1:0]         sample_class [STORE_DEPTH];
  logic [NBRB-1:0]         nbr_k   = 3'd1;
  logic [CNTB-1:0]         train_n = 9'd0;
  logic [4*FEAT_WIDTH-1:0] cluster_centre [CLASSES];

  knn_verdict_t expected_verdicts [$];

  int idle_pct = 21;
  int stall_pct = 21;
  int hold_request = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int items_sent = 0;
  int queries_sent = 0;
  int verdicts_checked = 0;
  int cfg_writes = 0;

  knn_classifier_top #(
    .TRAIN_DEPTH(STORE_DEPTH),
    .K_MAX(VOTE_MAX),
    .FEATURE_BITS(FEAT_WIDTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .entry_index(entry_index),
    .feat_a(feat_a),
    .feat_b(feat_b),
    .feat_c(feat_c),
    .feat_d(feat_d),
    .sample_label(sample_label),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .class_label(class_label),
    .nearest_distance(nearest_distance),
    .winning_votes(winning_votes),
    .no_samples(no_samples)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Classify a point against the shadow store with the current k and count
  function automatic knn_verdict_t classify_point(logic [4*FEAT_WIDTH-1:0] point);
    logic [63:0] best_dist [VOTE_MAX];
    logic [LBLB-1:0] best_cls [VOTE_MAX];
    int unsigned votes [CLASSES];
    int unsigned top;
    int k, span, filled, s, f, p, j;
    logic [63:0] d, diff;
    logic [FEAT_WIDTH-1:0] qf, sf;
    knn_verdict_t v;
    k = (nbr_k == 0) ? 1 : ((nbr_k > VOTE_MAX) ? VOTE_MAX : int'(nbr_k));
    span = (train_n > STORE_DEPTH) ? STORE_DEPTH : int'(train_n);
    filled = 0;
    for (s = 0; s < span; s++) begin
      d = '0;
      for (f = 0; f < 4; f++) begin
        qf = point[FEAT_WIDTH*f +: FEAT_WIDTH];
        sf = sample_feat[s][FEAT_WIDTH*f +: FEAT_WIDTH];
        diff = (qf > sf) ? 64'(qf - sf) : 64'(sf - qf);
        d += diff * diff;
      end
      // equal distances go behind the entries already listed
      p = 0;
      while (p < filled && best_dist[p] <= d) p++;
      if (p < k) begin
        if (filled < k) filled++;
        for (j = filled - 1; j > p; j--) begin
          best_dist[j] = best_dist[j-1];
          best_cls[j] = best_cls[j-1];
        end
        best_dist[p] = d;
        best_cls[p] = sample_class[s];
      end
    end
    v = '0;
    if (filled == 0) begin
      v.empty = 1'b1;
      return v;
    end
    for (j = 0; j < CLASSES; j++) votes[j] = 0;
    top = 0;
    for (p = 0; p < filled; p++) begin
      votes[best_cls[p]]++;
      if (votes[best_cls[p]] > top) top = votes[best_cls[p]];
    end
    // a tie goes to the tied class holding the nearest neighbour
    for (p = filled - 1; p >= 0; p--) begin
      if (votes[best_cls[p]] == top) v.label = best_cls[p];
    end
    v.nearest = best_dist[0][DSTB-1:0];
    v.votes = NBRB'(top);
    return v;
  endfunction

  function automatic knn_item_t make_item(logic req, logic [SLTB-1:0] slot,
                                          logic [4*FEAT_WIDTH-1:0] point,
                                          logic [LBLB-1:0] lbl);
    knn_item_t it;
    it.req = req;
    it.slot = slot;
    {it.fa, it.fb, it.fc, it.fd} = point;
    it.lbl = lbl;
    return it;
  endfunction

  function automatic logic [4*FEAT_WIDTH-1:0] pick_point(spread_t style,
                                                         logic [LBLB-1:0] lbl);
    logic [4*FEAT_WIDTH-1:0] point;
    int f;
    for (f = 0; f < 4; f++) begin
      case (style)
        SPREAD_CLUSTER: begin
          point[FEAT_WIDTH*f +: FEAT_WIDTH] = cluster_centre[lbl][FEAT_WIDTH*f +: FEAT_WIDTH]
              + 16'($urandom_range(2047)) - 16'd1024;
        end
        SPREAD_COARSE: begin
          case ($urandom_range(3))
            0: point[FEAT_WIDTH*f +: FEAT_WIDTH] = 16'h0000;
            1: point[FEAT_WIDTH*f +: FEAT_WIDTH] = 16'h0001;
            2: point[FEAT_WIDTH*f +: FEAT_WIDTH] = 16'h8000;
            default: point[FEAT_WIDTH*f +: FEAT_WIDTH] = FEAT_MAX;
          endcase
        end
        default: begin
          point[FEAT_WIDTH*f +: FEAT_WIDTH] = 16'($urandom);
        end
      endcase
    end
    return point;
  endfunction

  // Random query: often an exact copy of a stored sample, else a point in the given spread
  function automatic knn_item_t random_query(spread_t style);
    logic [4*FEAT_WIDTH-1:0] point;
    if ($urandom_range(3) == 0) point = sample_feat[$urandom_range(STORE_DEPTH - 1)];
    else point = pick_point(style, 3'($urandom));
    return make_item(knn_pkg::REQ_QUERY, 8'($urandom), point, 3'($urandom));
  endfunction

  // Random load: half of them land in the low slots that queries mostly read
  function automatic knn_item_t random_load(spread_t style);
    logic [LBLB-1:0] lbl;
    logic [SLTB-1:0] slot;
    logic [4*FEAT_WIDTH-1:0] point;
    lbl = 3'($urandom);
    slot = ($urandom_range(1) == 0) ? 8'($urandom_range(31)) : 8'($urandom);
    if ($urandom_range(7) == 0) point = sample_feat[$urandom_range(STORE_DEPTH - 1)];
    else point = pick_point(style, lbl);
    return make_item(knn_pkg::REQ_LOAD, slot, point, lbl);
  endfunction

  // Offer one item, hold it until accepted, then update the shadow
  task automatic send_item(knn_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= it.req;
    entry_index <= it.slot;
    feat_a <= it.fa;
    feat_b <= it.fb;
    feat_c <= it.fc;
    feat_d <= it.fd;
    sample_label <= it.lbl;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (it.req == knn_pkg::REQ_LOAD) begin
      if (int'(it.slot) < STORE_DEPTH) begin
        sample_feat[it.slot] = {it.fa, it.fb, it.fc, it.fd};
        sample_class[it.slot] = it.lbl;
      end
    end else begin
      queries_sent++;
      expected_verdicts.push_back(classify_point({it.fa, it.fb, it.fc, it.fd}));
    end
  endtask

  // Drop valid, wait for every verdict, then let a load finish
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDXB-1:0] idx, logic [DATB-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    case (idx)
      knn_pkg::CFG_NEIGHBOR_COUNT: begin
        nbr_k = data[NBRB-1:0];
      end
      knn_pkg::CFG_TRAIN_COUNT: begin
        train_n = data;
      end
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Corner points in the first slots, extremes of k and the count
  task automatic test_directed_cases();
    logic [4*FEAT_WIDTH-1:0] ones, zeros;
    ones = {4{FEAT_MAX}};
    zeros = '0;
    // nothing to compare against straight after reset
    send_item(make_item(knn_pkg::REQ_QUERY, 8'hFF, ones, 3'd7));
    wait_idle();
    write_reg(knn_pkg::CFG_NEIGHBOR_COUNT, 9'h1F8);  // k field reads zero, acts as one
    send_item(make_item(knn_pkg::REQ_QUERY, 8'h00, zeros, 3'd0));
    send_item(make_item(knn_pkg::REQ_LOAD, 8'd0, ones, 3'd7));
    send_item(make_item(knn_pkg::REQ_LOAD, 8'd1, zeros, 3'd0));
    send_item(make_item(knn_pkg::REQ_LOAD, 8'd2, zeros, 3'd3));
    send_item(make_item(knn_pkg::REQ_LOAD, 8'd3, {FEAT_MAX, 48'h0}, 3'd5));
    send_item(make_item(knn_pkg::REQ_LOAD, 8'd4, zeros, 3'd3));
    send_item(make_item(knn_pkg::REQ_LOAD, 8'd255, {4{16'h5A5A}}, 3'd6));
    wait_idle();
    // largest possible distance, then zero
    write_reg(knn_pkg::CFG_TRAIN_COUNT, 9'd1);
    send_item(make_item(knn_pkg::REQ_QUERY, 8'h00, zeros, 3'd0));
    send_item(make_item(knn_pkg::REQ_QUERY, 8'h00, ones, 3'd0));
    wait_idle();
    // equal distances: the lower slot counts as nearer
    write_reg(knn_pkg::CFG_TRAIN_COUNT, 9'd4);
    send_item(make_item(knn_pkg::REQ_QUERY, 8'h00, zeros, 3'd0));
    send_item(make_item(knn_pkg::REQ_QUERY, 8'h00, {16'h0, FEAT_MAX, 32'h0}, 3'd0));
    send_item(make_item(knn_pkg::REQ_QUERY, 8'h00, {32'h0, FEAT_MAX, 16'h0}, 3'd0));
    send_item(make_item(knn_pkg::REQ_QUERY, 8'h00, {48'h0, FEAT_MAX}, 3'd0));
    wait_idle();
    // k above the list size, and fewer samples than k
    write_reg(knn_pkg::CFG_NEIGHBOR_COUNT, 9'd7);
    send_item(make_item(knn_pkg::REQ_QUERY, 8'h00, zeros, 3'd0));
    send_item(make_item(knn_pkg::REQ_QUERY, 8'h00, ones, 3'd0));
    wait_idle();
    // plurality of two against one
    write_reg(knn_pkg::CFG_TRAIN_COUNT, 9'd5);
    write_reg(knn_pkg::CFG_NEIGHBOR_COUNT, 9'd3);
    send_item(make_item(knn_pkg::REQ_QUERY, 8'h00, zeros, 3'd0));
    wait_idle();
    // one vote each; a third equal distance is dropped from the full list
    write_reg(knn_pkg::CFG_NEIGHBOR_COUNT, 9'd2);
    send_item(make_item(knn_pkg::REQ_QUERY, 8'h00, zeros, 3'd0));
    send_item(make_item(knn_pkg::REQ_QUERY, 8'h00, {16'h0001, 48'h0}, 3'd0));
    wait_idle();
  endtask

  // Load every slot back to back, then query the whole store
  task automatic test_full_store();
    int s, n;
    logic [LBLB-1:0] lbl;
    logic [4*FEAT_WIDTH-1:0] point;
    for (s = 0; s < CLASSES; s++) cluster_centre[s] = {$urandom, $urandom};
    idle_pct = 0;
    for (s = 0; s < STORE_DEPTH; s++) begin
      lbl = 3'($urandom);
      if (s > 0 && $urandom_range(9) == 0) point = sample_feat[$urandom_range(s - 1)];
      else point = pick_point(SPREAD_CLUSTER, lbl);
      send_item(make_item(knn_pkg::REQ_LOAD, 8'(s), point, lbl));
    end
    wait_idle();
    idle_pct = 21;
    write_reg(knn_pkg::CFG_NEIGHBOR_COUNT, 9'd5);
    write_reg(knn_pkg::CFG_TRAIN_COUNT, 9'd256);
    for (n = 0; n < 3; n++) send_item(random_query(SPREAD_CLUSTER));
    wait_idle();
    // counts beyond the store saturate
    write_reg(knn_pkg::CFG_TRAIN_COUNT, 9'h1FF);
    for (n = 0; n < 2; n++) send_item(random_query(SPREAD_WIDE));
    wait_idle();
    write_reg(knn_pkg::CFG_TRAIN_COUNT, 9'd300);
    send_item(random_query(SPREAD_CLUSTER));
    wait_idle();
  endtask

  // Phases of mixed loads and queries under random settings
  task automatic test_mixed_traffic();
    int phase, n;
    spread_t style;
    logic [CNTB-1:0] count;
    for (phase = 0; phase < 8; phase++) begin
      idle_pct = (phase < 2) ? 0 : 21;
      stall_pct = (phase < 2) ? 0 : 21;
      style = spread_t'(phase % 3);
      write_reg(knn_pkg::CFG_NEIGHBOR_COUNT, {6'($urandom), 3'($urandom)});
      // mostly short walks, a few of the whole store
      case ($urandom_range(9))
        0: count = 9'd0;
        1: count = 9'($urandom_range(256, 511));
        2: count = 9'($urandom_range(255));
        default: count = 9'($urandom_range(1, 24));
      endcase
      write_reg(knn_pkg::CFG_TRAIN_COUNT, count);
      if (phase == 3) begin
        write_reg(CFG_SPARE_LO, 9'($urandom));
        write_reg(CFG_SPARE_HI, 9'h1FF);
      end
      for (n = 0; n < 20; n++) begin
        if ($urandom_range(99) < 40) send_item(random_load(style));
        else send_item(random_query(style));
      end
      wait_idle();
    end
    idle_pct = 21;
    stall_pct = 21;
  endtask

  // Hold the output off while queries keep coming, so the input stalls
  task automatic test_output_backpressure();
    int n;
    write_reg(knn_pkg::CFG_NEIGHBOR_COUNT, 9'd3);
    write_reg(knn_pkg::CFG_TRAIN_COUNT, 9'd8);
    idle_pct = 0;
    hold_request = HOLD_CYCLES;
    for (n = 0; n < 8; n++) send_item(random_query(SPREAD_CLUSTER));
    idle_pct = 21;
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_full_store();
    test_mixed_traffic();
    test_output_backpressure();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d items (%0d queries) and %0d register writes.",
             items_sent, queries_sent, cfg_writes);
    $display("Checked %0d verdicts, %0d field mismatches.", verdicts_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Drive out_ready: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each verdict with the oldest one predicted
  always @(posedge clk) begin
    knn_verdict_t want;
    if (!rst && out_valid && out_ready) begin
      verdicts_checked++;
      if (expected_verdicts.size() == 0) begin
        $error("verdict with none predicted: class_label %0d nearest_distance %0d",
               class_label, nearest_distance);
        mismatch_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (class_label !== want.label) begin
          $error("class_label: expected %0d, got %0d", want.label, class_label);
          mismatch_count++;
        end
        if (nearest_distance !== want.nearest) begin
          $error("nearest_distance: expected %0d, got %0d", want.nearest, nearest_distance);
          mismatch_count++;
        end
        if (winning_votes !== want.votes) begin
          $error("winning_votes: expected %0d, got %0d", want.votes, winning_votes);
          mismatch_count++;
        end
        if (no_samples !== want.empty) begin
          $error("no_samples: expected %0d, got %0d", want.empty, no_samples);
          mismatch_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d verdicts outstanding.",
               cycle_count, expected_verdicts.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
